### hdl/unit_disk_graph_reachability_assert.svh
// Assertion macros shared by the checker.
`ifndef UNIT_DISK_GRAPH_REACHABILITY_ASSERT_SVH
`define UNIT_DISK_GRAPH_REACHABILITY_ASSERT_SVH
`define UDG_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UDG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

### hdl/udgr_pkg.sv
// ------------------------------------------------------------------------
// udgr_pkg
// Shared constants and types of the unit-disk reachability block.
// ------------------------------------------------------------------------
package udgr_pkg;
    localparam int MaxNodes = 16;
    localparam int IdxW = 4;
    localparam int CoordW = 12;
    localparam int CountW = 5;
    localparam logic [CountW-1:0] NodeCountReset = 5'd10;
    localparam logic [CoordW-1:0] LinkRadiusReset = 12'd800;
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdQuery = 1'b1;
    localparam logic [0:0] RegNodeCount = 1'b0;
    localparam logic [0:0] RegLinkRadius = 1'b1;

    typedef logic [MaxNodes-1:0] node_mask_t;

    typedef struct packed {
        logic [IdxW-1:0]   node_index;
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic              cmd_valid;
        logic [CoordW-1:0] link_radius;
    } udgr_cell_ctl_t;

    typedef struct packed {
        logic              command;
        logic [IdxW-1:0]   node_index;
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [IdxW-1:0]   source_node;
        logic [IdxW-1:0]   target_node;
    } udgr_in_t;

    typedef struct packed {
        logic reachable;
        logic status;
    } udgr_out_t;
endpackage

### hdl/udgr_if.sv
// ------------------------------------------------------------------------
// udgr_in_if / udgr_out_if
// Valid/ready channels carrying input and result items.
// ------------------------------------------------------------------------
interface udgr_in_if;
    logic valid;
    logic ready;
    udgr_pkg::udgr_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface udgr_out_if;
    logic valid;
    logic ready;
    udgr_pkg::udgr_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/udgr_cell.sv
// ------------------------------------------------------------------------
// udgr_cell
// One node cell: holds position, passes the new position one cell along and
// computes the link bit against the position that passes it.
// ------------------------------------------------------------------------
module udgr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [udgr_pkg::IdxW-1:0]     my_index,
    input  udgr_pkg::udgr_cell_ctl_t      ctl_in,
    output udgr_pkg::udgr_cell_ctl_t      ctl_out,
    output logic                          link_valid,
    output logic                          link_bit
);
    import udgr_pkg::*;

    logic [CoordW-1:0] x_reg;
    logic [CoordW-1:0] y_reg;
    udgr_cell_ctl_t    ctl_reg;
    logic [CoordW-1:0] dx, dy;
    logic [2*CoordW-1:0] dx2_reg, dy2_reg, r2_reg;
    logic              same_reg;
    logic              v1_reg;
    logic              writes_me;

    assign writes_me = ctl_in.cmd_valid && (ctl_in.node_index == my_index);
    assign dx = (ctl_in.pos_x > x_reg) ? ctl_in.pos_x - x_reg : x_reg - ctl_in.pos_x;
    assign dy = (ctl_in.pos_y > y_reg) ? ctl_in.pos_y - y_reg : y_reg - ctl_in.pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            ctl_reg <= '0;
            v1_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_in;
            v1_reg <= ctl_in.cmd_valid;
            if (writes_me)
            begin
                x_reg <= ctl_in.pos_x;
                y_reg <= ctl_in.pos_y;
            end
        end
    end

    // Squares are registered before the sum and compare.
    always_ff @(posedge clk)
    begin
        dx2_reg  <= dx * dx;
        dy2_reg  <= dy * dy;
        r2_reg   <= ctl_in.link_radius * ctl_in.link_radius;
        same_reg <= (ctl_in.node_index == my_index);
    end

    assign ctl_out = ctl_reg;
    assign link_valid = v1_reg;
    assign link_bit = same_reg ||
        ({1'b0, dx2_reg} + {1'b0, dy2_reg} <= {1'b0, r2_reg});
endmodule

### hdl/unit_disk_graph_reachability.sv
// One item at a time: a new item is accepted only once the result of the
// last one has been taken.
// A write streams its position through the row of node cells, one cell a
// cycle; a query expands the reached set one breadth step a cycle.
// Reset clears positions to zero, the matrix to identity and restores the
// register defaults.
// ------------------------------------------------------------------------
// unit_disk_graph_reachability
// Top level: sequencer, adjacency matrix and the chain of node cells.
// ------------------------------------------------------------------------
module unit_disk_graph_reachability (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [udgr_pkg::CoordW-1:0] cfg_data,
    udgr_in_if.sink                     in_ch,
    udgr_out_if.source                  out_ch
);
    import udgr_pkg::*;

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StWrite = 2'd1;
    localparam logic [1:0] StQuery = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CountW-1:0] node_count_reg;
    logic [CoordW-1:0] link_radius_reg;
    node_mask_t        adj_reg [MaxNodes];
    node_mask_t        reached_reg;
    logic [IdxW-1:0]   wr_node_reg;
    logic [IdxW-1:0]   target_reg;
    logic [CountW:0]   cnt_reg;
    udgr_out_t         res_reg;
    logic              res_valid_reg;

    udgr_cell_ctl_t    chain [MaxNodes+1];
    logic              lv [MaxNodes];
    logic              lb [MaxNodes];

    logic [CountW-1:0] n_use;
    node_mask_t        active;
    node_mask_t        grown;
    logic              accept;
    logic              query_ok;

    assign n_use = (node_count_reg > CountW'(MaxNodes)) ? CountW'(MaxNodes) : node_count_reg;
    always_comb
    begin
        for (int i = 0; i < MaxNodes; i++)
            active[i] = (CountW'(i) < n_use);
    end

    always_comb
    begin
        grown = reached_reg;
        for (int i = 0; i < MaxNodes; i++)
            if (reached_reg[i])
                grown = grown | adj_reg[i];
        grown = grown & active;
    end

    assign in_ch.ready = (state_reg == StIdle) && !res_valid_reg;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data = res_reg;

    assign query_ok = accept && (in_ch.data.command == CmdQuery) &&
                      ({1'b0, in_ch.data.source_node} < n_use) &&
                      ({1'b0, in_ch.data.target_node} < n_use);

    assign chain[0].cmd_valid   = accept && (in_ch.data.command == CmdWrite) &&
                                  ({1'b0, in_ch.data.node_index} < n_use);
    assign chain[0].node_index  = in_ch.data.node_index;
    assign chain[0].pos_x       = in_ch.data.pos_x;
    assign chain[0].pos_y       = in_ch.data.pos_y;
    assign chain[0].link_radius = link_radius_reg;

    for (genvar g = 0; g < MaxNodes; g++)
    begin : g_cell
        udgr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .my_index   (IdxW'(g)),
            .ctl_in     (chain[g]),
            .ctl_out    (chain[g+1]),
            .link_valid (lv[g]),
            .link_bit   (lb[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle:  state_next = StIdle;
            StWrite: if (cnt_reg == (CountW+1)'(MaxNodes)) state_next = StIdle;
            StQuery: if (grown == reached_reg) state_next = StIdle;
            default: state_next = StIdle;
        endcase
        if (accept && chain[0].cmd_valid)
            state_next = StWrite;
        else if (query_ok)
            state_next = StQuery;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            node_count_reg <= NodeCountReset;
            link_radius_reg <= LinkRadiusReset;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < MaxNodes; i++)
                adj_reg[i] <= node_mask_t'(1) << i;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegNodeCount:  node_count_reg <= cfg_data[CountW-1:0];
                    RegLinkRadius: link_radius_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                res_valid_reg <= 1'b0;
            // Link bits leave the cells one per cycle as the position moves on.
            for (int j = 0; j < MaxNodes; j++)
                if (lv[j])
                begin
                    adj_reg[wr_node_reg][j] <= lb[j];
                    if (IdxW'(j) != wr_node_reg)
                        adj_reg[j][wr_node_reg] <= lb[j];
                end
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
                if (in_ch.data.command == CmdWrite)
                begin
                    res_reg.reachable <= 1'b0;
                    res_reg.status <= !chain[0].cmd_valid;
                    if (!chain[0].cmd_valid)
                        res_valid_reg <= 1'b1;
                end
                else if (!query_ok)
                begin
                    res_reg <= '{reachable: 1'b0, status: 1'b1};
                    res_valid_reg <= 1'b1;
                end
                else
                    res_reg.status <= 1'b0;
            end
            else if (state_reg == StWrite)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == (CountW+1)'(MaxNodes))
                    res_valid_reg <= 1'b1;
            end
            else if (state_reg == StQuery)
            begin
                if (grown == reached_reg)
                begin
                    res_reg.reachable <= reached_reg[target_reg];
                    res_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_node_reg <= in_ch.data.node_index;
            target_reg <= in_ch.data.target_node;
            reached_reg <= node_mask_t'(1) << in_ch.data.source_node;
        end
        else
            reached_reg <= grown;
    end
endmodule

### hdl/udgr_checker.sv
// ------------------------------------------------------------------------
// udgr_checker
// Port-level checks of the reachability block, bound to the top level.
// ------------------------------------------------------------------------
`include "unit_disk_graph_reachability_assert.svh"
module udgr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_reachable,
    input logic out_status
);
    // A result never leaves with both a path and an error.
    `UDG_ASSERT_IMPL(a_no_reach_on_err, clk, rst_n, !(out_valid && out_status && out_reachable), "reachable with error status")
    // The block takes no item while a result is waiting.
    `UDG_ASSERT_IMPL(a_busy_out, clk, rst_n, !(out_valid && in_ready), "input ready with result pending")
    // A stalled result holds.
    `UDG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped")
    // After an accepted item the block is busy.
    `UDG_ASSERT_NEXT(a_busy_in, clk, rst_n, in_valid && in_ready, !in_ready, "accepted two items back to back")
endmodule

bind unit_disk_graph_reachability udgr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_reachable (out_ch.data.reachable),
    .out_status    (out_ch.data.status)
);

### sim/tb_channels.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_channels
// Handshake-timing helper for the item channels, compiled with the testbench.
// ------------------------------------------------------------------------
// The channel interfaces live in hdl/udgr_if.sv; this file only holds the
// handshake-timing helper shared by the testbench.
package tb_chan_pkg;
    // Random hold-off: true when a side should idle this cycle.
    function automatic bit idle_now(int unsigned pct);
        return $urandom_range(99, 0) < pct;
    endfunction
endpackage

### sim/tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb
// Self-checking bench for the unit-disk reachability block: positions are
// written and reachability queried, and each result is compared with a
// behavioural model of the adjacency matrix and the frontier search.
// ------------------------------------------------------------------------
module tb;
    import udgr_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = RegNodeCount;
    logic [CoordW-1:0] cfg_data = '0;

    udgr_in_if in_ch ();
    udgr_out_if out_ch ();

    unit_disk_graph_reachability dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state
    logic [CoordW-1:0] pos_x_mem [MaxNodes];
    logic [CoordW-1:0] pos_y_mem [MaxNodes];
    node_mask_t        link_rows [MaxNodes];
    logic [CountW-1:0] count_reg;
    logic [CoordW-1:0] radius_reg;

    udgr_out_t pending_results [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int errors = 0;
    longint cycles = 0;

    function automatic bit in_range_link(int a, int b);
        longint dx, dy, r;
        if (a == b)
            return 1'b1;
        dx = longint'(pos_x_mem[a]) - longint'(pos_x_mem[b]);
        dy = longint'(pos_y_mem[a]) - longint'(pos_y_mem[b]);
        r = radius_reg;
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic udgr_out_t predict_item(udgr_in_t it);
        udgr_out_t res;
        int n;
        node_mask_t active, reached, grown;
        res = '0;
        n = (count_reg > MaxNodes) ? MaxNodes : count_reg;
        active = '0;
        for (int i = 0; i < n; i++)
            active[i] = 1'b1;
        if (it.command == CmdWrite)
        begin
            if (it.node_index >= n)
                res.status = 1'b1;
            else
            begin
                pos_x_mem[it.node_index] = it.pos_x;
                pos_y_mem[it.node_index] = it.pos_y;
                for (int j = 0; j < MaxNodes; j++)
                begin
                    link_rows[it.node_index][j] = in_range_link(it.node_index, j);
                    link_rows[j][it.node_index] = in_range_link(it.node_index, j);
                end
            end
        end
        else if (it.source_node >= n || it.target_node >= n)
            res.status = 1'b1;
        else if (it.source_node == it.target_node)
            res.reachable = 1'b1;
        else
        begin
            reached = '0;
            reached[it.source_node] = 1'b1;
            forever
            begin
                grown = reached;
                for (int i = 0; i < n; i++)
                    if (reached[i])
                        grown |= link_rows[i];
                grown &= active;
                if (grown == reached)
                    break;
                reached = grown;
            end
            res.reachable = reached[it.target_node];
        end
        return res;
    endfunction

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %b", out_ch.data);
            end
            else
            begin
                udgr_out_t exp_res;
                exp_res = pending_results.pop_front();
                if (exp_res.reachable !== out_ch.data.reachable ||
                    exp_res.status !== out_ch.data.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result differs: expected r=%b s=%b got r=%b s=%b",
                                 exp_res.reachable, exp_res.status,
                                 out_ch.data.reachable, out_ch.data.status);
                end
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= rst_n && !tb_chan_pkg::idle_now(recv_idle_pct);

    always @(posedge clk)
        if (cycles > 3000000)
        begin
            $display("unit_disk_graph_reachability: mismatch");
            $finish;
        end

    // The block is busy in the cycle after an item, so the falling-edge wait
    // before driving again costs no throughput.
    task automatic send_item(udgr_in_t it);
        @(negedge clk);
        while (tb_chan_pkg::idle_now(send_idle_pct))
            @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_item(it));
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MaxNodes + 8)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [CoordW-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == RegNodeCount)
            count_reg = val[CountW-1:0];
        else
            radius_reg = val;
    endtask

    function automatic udgr_in_t make_write(int k, int x, int y);
        udgr_in_t it;
        it = udgr_in_t'($urandom());
        it.command = CmdWrite;
        it.node_index = IdxW'(k);
        it.pos_x = CoordW'(x);
        it.pos_y = CoordW'(y);
        return it;
    endfunction

    function automatic udgr_in_t make_query(int s, int t);
        udgr_in_t it;
        it = udgr_in_t'($urandom());
        it.command = CmdQuery;
        it.source_node = IdxW'(s);
        it.target_node = IdxW'(t);
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_query(0, 0));
        send_item(make_query(0, 9));
        send_item(make_query(10, 2));
        send_item(make_query(3, 15));
        send_item(make_write(15, 4095, 4095));
        send_item(make_write(0, 0, 0));
        send_item(make_write(1, 800, 0));
        send_item(make_write(2, 1600, 1));
        send_item(make_query(0, 1));
        send_item(make_query(0, 2));
        send_item(make_write(2, 1600, 0));
        send_item(make_query(0, 2));
        send_item(make_query(2, 0));
        send_item(make_write(9, 4095, 4095));
        send_item(make_query(9, 0));
        write_reg(RegNodeCount, CoordW'(16));
        write_reg(RegLinkRadius, CoordW'(4095));
        send_item(make_write(15, 4095, 4095));
        send_item(make_query(0, 15));
        write_reg(RegLinkRadius, CoordW'(0));
        send_item(make_write(3, 0, 0));
        send_item(make_query(0, 3));
        send_item(make_query(1, 0));
        write_reg(RegNodeCount, CoordW'(0));
        send_item(make_write(0, 1, 1));
        send_item(make_query(0, 0));
    endtask

    task automatic test_random(int items);
        int n;
        for (int i = 0; i < items; i++)
        begin
            if (i % 60 == 0)
            begin
                write_reg(RegNodeCount, CoordW'($urandom_range(3) == 0 ?
                          $urandom_range(31) : $urandom_range(16, 1)));
                write_reg(RegLinkRadius, CoordW'($urandom_range(3) == 0 ?
                          $urandom_range(4095) : $urandom_range(1200, 200)));
            end
            n = (count_reg == 0) ? 1 : (count_reg > 16 ? 16 : count_reg);
            if ($urandom_range(1))
                send_item(make_write($urandom_range(9) == 0 ? $urandom_range(15) :
                                     $urandom_range(n - 1),
                                     $urandom_range(3) == 0 ? $urandom_range(4095) :
                                     $urandom_range(2000), $urandom_range(3) == 0 ?
                                     $urandom_range(4095) : $urandom_range(2000)));
            else
                send_item(make_query($urandom_range(9) == 0 ? $urandom_range(15) :
                                     $urandom_range(n - 1), $urandom_range(9) == 0 ?
                                     $urandom_range(15) : $urandom_range(n - 1)));
            if (i == items / 2)
                drain();
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        count_reg = NodeCountReset;
        radius_reg = LinkRadiusReset;
        for (int i = 0; i < MaxNodes; i++)
        begin
            pos_x_mem[i] = '0;
            pos_y_mem[i] = '0;
            link_rows[i] = '0;
            link_rows[i][i] = 1'b1;
        end
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        send_idle_pct = 29;
        recv_idle_pct = 68;
        test_random(475);
        send_idle_pct = 68;
        recv_idle_pct = 29;
        test_random(475);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(475);
        drain();
        if (errors == 0)
            $display("unit_disk_graph_reachability: match");
        else
            $display("unit_disk_graph_reachability: mismatch");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/udgr_pkg.sv
hdl/udgr_if.sv
hdl/udgr_cell.sv
hdl/unit_disk_graph_reachability.sv
hdl/udgr_checker.sv
sim/tb_channels.sv
sim/tb.sv
